### hdl/iapd_pkg.sv
package iapd_pkg;

  localparam int unsigned MAX_PARTIES = 8;
  localparam int unsigned STACK_DEPTH = 16;
  localparam int unsigned QUEUE_DEPTH = 16;

  localparam int unsigned PARTY_W     = 3;
  localparam int unsigned SLOT_W      = 4;
  localparam int unsigned PC_W        = 4;
  localparam int unsigned FILL_W      = 5;
  localparam int unsigned LIM_W       = 5;
  localparam int unsigned STK_ENTRIES = MAX_PARTIES * STACK_DEPTH;
  localparam int unsigned QUE_ENTRIES = MAX_PARTIES * QUEUE_DEPTH;

  typedef enum logic [1:0] {
    ACT_ADD_INT  = 2'd0,
    ACT_ADD_PROC = 2'd1,
    ACT_SEND     = 2'd2,
    ACT_OPERATE  = 2'd3
  } action_e;

  localparam logic [7:0] ERR_QUEUE_FULL = 8'd0;
  localparam logic [7:0] ERR_STACK_FULL = 8'd1;
  localparam logic [7:0] ERR_NOTHING    = 8'd2;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PARTY_COUNT  = 3'd0,
    CFG_CLIENT_STACK = 3'd1,
    CFG_CLIENT_QUEUE = 3'd2,
    CFG_SERVER_STACK = 3'd3,
    CFG_SERVER_QUEUE = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0] action;
    logic [2:0] party;
    logic [7:0] item_char;
  } cmd_t;

  typedef struct packed {
    logic [2:0] log_party;
    logic       is_error;
    logic [7:0] log_value;
    logic       last_entry;
  } log_t;

endpackage

### hdl/iapd_if.sv
interface iapd_cmd_if;
  import iapd_pkg::*;
  logic valid;
  logic ready;
  cmd_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface iapd_log_if;
  import iapd_pkg::*;
  logic valid;
  logic ready;
  log_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hdl/interrupt_and_process_dispatcher_top.sv
// A command passes the front queue, then the engine's issue step in ST_IDLE,
// ST_EXEC for send and operate, and the log states ST_OUT1 (and ST_OUT2);
// an add that reports a full stack or queue goes from issue straight to ST_OUT1.
// The engine takes no new command until it is back in ST_IDLE; log stalls hold it.
// Reset (rst_ni low, async) empties all stacks and queues and restores the
// configuration registers to 8, 16, 16, 16, 16.
module interrupt_and_process_dispatcher_top
  import iapd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  iapd_cmd_if.sink              cmd,
  iapd_log_if.source            log
);
  logic [PC_W-1:0]  pc_q;
  logic [LIM_W-1:0] cs_q, cq_q, ss_q, sq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= 4'd8; cs_q <= 5'd16; cq_q <= 5'd16; ss_q <= 5'd16; sq_q <= 5'd16;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PARTY_COUNT:  pc_q <= cfg_data_i[PC_W-1:0];
        CFG_CLIENT_STACK: cs_q <= cfg_data_i;
        CFG_CLIENT_QUEUE: cq_q <= cfg_data_i;
        CFG_SERVER_STACK: ss_q <= cfg_data_i;
        CFG_SERVER_QUEUE: sq_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic q_valid, q_pop;
  cmd_t q_data;

  iapd_front u_front (
    .clk_i, .rst_ni, .cmd,
    .q_valid_o(q_valid), .q_data_o(q_data), .q_pop_i(q_pop)
  );

  iapd_back u_back (
    .clk_i, .rst_ni,
    .q_valid_i(q_valid), .q_data_i(q_data), .q_pop_o(q_pop),
    .party_count_i(pc_q), .cs_lim_i(cs_q), .cq_lim_i(cq_q),
    .ss_lim_i(ss_q), .sq_lim_i(sq_q), .log
  );
endmodule

### hdl/iapd_front.sv
// Two-entry command queue feeding the engine.
module iapd_front
  import iapd_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  iapd_cmd_if.sink     cmd,
  output logic         q_valid_o,
  output cmd_t         q_data_o,
  input  logic         q_pop_i
);
  cmd_t       mem_q [2];
  logic [1:0] cnt_q, cnt_d;
  logic       rd_q, wr_q;
  logic       push;

  assign cmd.ready = (cnt_q != 2'd2);
  assign push      = cmd.valid && cmd.ready;
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_data_o  = mem_q[rd_q];

  always_comb begin
    cnt_d = cnt_q + {1'b0, push} - {1'b0, q_pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rd_q  <= 1'b0;
      wr_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wr_q <= ~wr_q;
      if (q_pop_i) rd_q <= ~rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= cmd.data;
  end
endmodule

### hdl/iapd_back.sv
// Executes one command: the issue cycle updates fills and reads the stack
// and queue, the exec cycle (send and operate only) forwards a sent item to
// the server queue, then one or two log entries go out; an error-free add logs none.
module iapd_back
  import iapd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  input  cmd_t             q_data_i,
  output logic             q_pop_o,
  input  logic [PC_W-1:0]  party_count_i,
  input  logic [LIM_W-1:0] cs_lim_i,
  input  logic [LIM_W-1:0] cq_lim_i,
  input  logic [LIM_W-1:0] ss_lim_i,
  input  logic [LIM_W-1:0] sq_lim_i,
  iapd_log_if.source       log
);
  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_EXEC  = 4'b0010,
    ST_OUT1  = 4'b0100,
    ST_OUT2  = 4'b1000
  } state_e;

  function automatic logic [LIM_W-1:0] clamp_lim(logic [LIM_W-1:0] lim,
                                                  logic [LIM_W-1:0] hi);
    logic [LIM_W-1:0] r;
    r = lim;
    if (r == '0) r = LIM_W'(1);
    if (r > hi) r = hi;
    return r;
  endfunction

  state_e state_q, state_d;

  logic [7:0] stk_mem [STK_ENTRIES];
  logic [7:0] que_mem [QUE_ENTRIES];
  logic [FILL_W-1:0] sfill_q [MAX_PARTIES];
  logic [FILL_W-1:0] qfill_q [MAX_PARTIES];
  logic [SLOT_W-1:0] qhead_q [MAX_PARTIES];

  action_e            act;
  logic [PC_W-1:0]    np_c, last_c;
  logic [PARTY_W-1:0] p, srv, tp;
  logic               p_ok, is_srv;
  logic [LIM_W-1:0]   scap, qcap, sqcap;
  logic               s_full, q_full, take_cmd, stk_hit, que_hit;
  logic [SLOT_W-1:0]  stk_top, p_tail;
  logic               start;

  action_e            act_q;
  logic [PARTY_W-1:0] tp_q, srv_q;
  logic               hit_q, from_stk_q, two_q;
  logic [7:0]         rd_stk_q, rd_que_q;
  log_t               ent0_q, ent1;

  logic [7:0]         take_v;
  logic               fwd_full, fwd, fwd_err;
  logic [SLOT_W-1:0]  srv_tail;

  logic                      stk_we, que_we;
  logic [PARTY_W+SLOT_W-1:0] stk_waddr, que_waddr;
  logic [7:0]                que_wdata;

  // decode of the command at the head of the queue
  always_comb begin
    act  = action_e'(q_data_i.action);
    np_c = party_count_i;
    if (np_c < PC_W'(2)) np_c = PC_W'(2);
    if (np_c > PC_W'(MAX_PARTIES)) np_c = PC_W'(MAX_PARTIES);
    last_c   = np_c - PC_W'(1);
    srv      = last_c[PARTY_W-1:0];
    p        = q_data_i.party;
    p_ok     = {1'b0, p} < np_c;
    is_srv   = (p == srv);
    scap     = clamp_lim(is_srv ? ss_lim_i : cs_lim_i, LIM_W'(STACK_DEPTH));
    qcap     = clamp_lim(is_srv ? sq_lim_i : cq_lim_i, LIM_W'(QUEUE_DEPTH));
    sqcap    = clamp_lim(sq_lim_i, LIM_W'(QUEUE_DEPTH));
    s_full   = sfill_q[p] >= scap;
    q_full   = qfill_q[p] >= qcap;
    p_tail   = qhead_q[p] + qfill_q[p][SLOT_W-1:0];
    take_cmd = (act == ACT_OPERATE) || (act == ACT_SEND && p_ok);
    tp       = (act == ACT_OPERATE) ? srv : p;
    stk_hit  = sfill_q[tp] != '0;
    que_hit  = qfill_q[tp] != '0;
    stk_top  = sfill_q[tp][SLOT_W-1:0] - SLOT_W'(1);
  end

  assign start   = (state_q == ST_IDLE) && q_valid_i;
  assign q_pop_o = start;

  assign take_v   = from_stk_q ? rd_stk_q : rd_que_q;
  assign fwd_full = qfill_q[srv_q] >= sqcap;
  assign srv_tail = qhead_q[srv_q] + qfill_q[srv_q][SLOT_W-1:0];
  assign fwd_err  = (act_q == ACT_SEND) && hit_q && fwd_full;
  assign fwd      = (state_q == ST_EXEC) && (act_q == ACT_SEND) && hit_q && !fwd_full;

  assign stk_we    = start && (act == ACT_ADD_INT) && p_ok && !s_full;
  assign stk_waddr = {p, sfill_q[p][SLOT_W-1:0]};

  // one queue write port shared by add process and the forward to the server
  always_comb begin
    que_we    = 1'b0;
    que_waddr = {p, p_tail};
    que_wdata = q_data_i.item_char;
    if (start && (act == ACT_ADD_PROC) && p_ok && !q_full) begin
      que_we = 1'b1;
    end else if (fwd) begin
      que_we    = 1'b1;
      que_waddr = {srv_q, srv_tail};
      que_wdata = take_v;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (start) begin
        unique case (act)
          ACT_ADD_INT:  if (p_ok && s_full) state_d = ST_OUT1;
          ACT_ADD_PROC: if (p_ok && q_full) state_d = ST_OUT1;
          ACT_SEND, ACT_OPERATE: if (take_cmd) state_d = ST_EXEC;
        endcase
      end
      ST_EXEC: state_d = ST_OUT1;
      ST_OUT1: if (log.ready) state_d = two_q ? ST_OUT2 : ST_IDLE;
      ST_OUT2: if (log.ready) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      act_q      <= ACT_ADD_INT;
      tp_q       <= '0;
      srv_q      <= '0;
      hit_q      <= 1'b0;
      from_stk_q <= 1'b0;
      two_q      <= 1'b0;
      ent0_q     <= '0;
      for (int i = 0; i < MAX_PARTIES; i++) begin
        sfill_q[i] <= '0;
        qfill_q[i] <= '0;
        qhead_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (start) begin
        act_q      <= act;
        tp_q       <= tp;
        srv_q      <= srv;
        hit_q      <= stk_hit || que_hit;
        from_stk_q <= stk_hit;
        two_q      <= 1'b0;
        if (act == ACT_ADD_INT && p_ok) begin
          if (s_full) ent0_q <= '{p, 1'b1, ERR_STACK_FULL, 1'b1};
          else sfill_q[p] <= sfill_q[p] + FILL_W'(1);
        end
        if (act == ACT_ADD_PROC && p_ok) begin
          if (q_full) ent0_q <= '{p, 1'b1, ERR_QUEUE_FULL, 1'b1};
          else qfill_q[p] <= qfill_q[p] + FILL_W'(1);
        end
        // newest interrupt first, else oldest process
        if (take_cmd) begin
          if (stk_hit) begin
            sfill_q[tp] <= sfill_q[tp] - FILL_W'(1);
          end else if (que_hit) begin
            qhead_q[tp] <= qhead_q[tp] + SLOT_W'(1);
            qfill_q[tp] <= qfill_q[tp] - FILL_W'(1);
          end
        end
      end
      if (state_q == ST_EXEC) begin
        if (hit_q) begin
          ent0_q <= '{tp_q, 1'b0, take_v, !fwd_err};
          two_q  <= fwd_err;
          if (fwd) qfill_q[srv_q] <= qfill_q[srv_q] + FILL_W'(1);
        end else begin
          ent0_q <= '{tp_q, 1'b1, ERR_NOTHING, 1'b1};
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) stk_mem[stk_waddr] <= q_data_i.item_char;
    if (que_we) que_mem[que_waddr] <= que_wdata;
    if (start && take_cmd) begin
      rd_stk_q <= stk_mem[{tp, stk_top}];
      rd_que_q <= que_mem[{tp, qhead_q[tp]}];
    end
  end

  assign ent1      = '{srv_q, 1'b1, ERR_QUEUE_FULL, 1'b1};
  assign log.valid = (state_q == ST_OUT1) || (state_q == ST_OUT2);
  assign log.data  = (state_q == ST_OUT2) ? ent1 : ent0_q;
endmodule

### hdl/iapd_checker.sv
module iapd_checker
  import iapd_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic log_valid,
  input logic log_ready,
  input log_t log_data,
  input logic cmd_valid,
  input logic cmd_ready
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    log_valid && !log_ready |=> log_valid && $stable(log_data))
    else $error("log entry dropped while stalled");
  a_err_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    log_valid && log_data.is_error |-> log_data.log_value == ERR_QUEUE_FULL
      || log_data.log_value == ERR_STACK_FULL || log_data.log_value == ERR_NOTHING)
    else $error("bad error code");
  a_second: assert property (@(posedge clk_i) disable iff (!rst_ni)
    log_valid && log_ready && !log_data.last_entry |=> log_valid && log_data.is_error)
    else $error("second entry missing");
  a_cmd_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid && !cmd_ready |=> cmd_valid)
    else $error("command withdrawn before transfer");
endmodule

bind interrupt_and_process_dispatcher_top iapd_checker u_chk (
  .clk_i, .rst_ni,
  .log_valid(log.valid), .log_ready(log.ready), .log_data(log.data),
  .cmd_valid(cmd.valid), .cmd_ready(cmd.ready)
);

### verif/tb.sv
`timescale 1ns / 1ps

module tb;
  import iapd_pkg::*;

  localparam int unsigned NPARTY    = 8;
  localparam int unsigned STK_DEPTH = 16;
  localparam int unsigned Q_DEPTH   = 16;
  localparam int unsigned DRAIN_CYC = 12;
  localparam int unsigned CYC_LIMIT = 400000;
  localparam int unsigned HOLD_CYC  = 300;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 3'd7;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  iapd_cmd_if cmd_if ();
  iapd_log_if log_if ();

  interrupt_and_process_dispatcher_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cmd        (cmd_if.sink),
    .log        (log_if.source)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // shadow state of the dispatcher
  logic [3:0] sh_parties;
  logic [4:0] sh_cstk, sh_cq, sh_sstk, sh_sq;
  logic [7:0] stk_mem [NPARTY*STK_DEPTH];
  logic [7:0] q_mem [NPARTY*Q_DEPTH];
  int unsigned stk_cnt [NPARTY];
  int unsigned q_head [NPARTY];
  int unsigned q_cnt [NPARTY];

  cmd_t pending_cmds[$];
  log_t expected_logs[$];
  int unsigned issued, accepted, log_seen, err_seen, mismatches;
  int unsigned cycles;

  function automatic int unsigned clampu(int unsigned v, int unsigned lo, int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int unsigned party_total();
    return clampu(sh_parties, 2, NPARTY);
  endfunction

  function automatic void log_entry(int unsigned p, logic err, logic [7:0] val);
    log_t e;
    e.log_party  = p[2:0];
    e.is_error   = err;
    e.log_value  = val;
    e.last_entry = 1'b0;
    expected_logs.push_back(e);
  endfunction

  function automatic bit fetch_item(int unsigned p, output logic [7:0] v);
    if (stk_cnt[p] > 0) begin
      stk_cnt[p]--;
      v = stk_mem[p*STK_DEPTH + stk_cnt[p]];
      return 1;
    end
    if (q_cnt[p] > 0) begin
      v = q_mem[p*Q_DEPTH + q_head[p]];
      q_head[p] = (q_head[p] + 1) % Q_DEPTH;
      q_cnt[p]--;
      return 1;
    end
    return 0;
  endfunction

  function automatic bit enqueue_proc(int unsigned p, int unsigned cap, logic [7:0] v);
    if (q_cnt[p] >= cap) return 0;
    q_mem[p*Q_DEPTH + (q_head[p] + q_cnt[p]) % Q_DEPTH] = v;
    q_cnt[p]++;
    return 1;
  endfunction

  function automatic void dispatch_cmd(cmd_t c);
    int unsigned np, srv, p, n0, scap, qcap;
    logic [7:0] v;
    np  = party_total();
    srv = np - 1;
    p   = c.party;
    n0  = expected_logs.size();
    scap = clampu((p == srv) ? sh_sstk : sh_cstk, 1, STK_DEPTH);
    qcap = clampu((p == srv) ? sh_sq : sh_cq, 1, Q_DEPTH);
    if (action_e'(c.action) == ACT_OPERATE) begin
      if (fetch_item(srv, v)) log_entry(srv, 1'b0, v);
      else log_entry(srv, 1'b1, ERR_NOTHING);
    end else if (p < np) begin
      case (action_e'(c.action))
        ACT_ADD_INT: begin
          if (stk_cnt[p] >= scap) log_entry(p, 1'b1, ERR_STACK_FULL);
          else begin
            stk_mem[p*STK_DEPTH + stk_cnt[p]] = c.item_char;
            stk_cnt[p]++;
          end
        end
        ACT_ADD_PROC: begin
          if (!enqueue_proc(p, qcap, c.item_char)) log_entry(p, 1'b1, ERR_QUEUE_FULL);
        end
        default: begin
          if (fetch_item(p, v)) begin
            log_entry(p, 1'b0, v);
            if (!enqueue_proc(srv, clampu(sh_sq, 1, Q_DEPTH), v))
              log_entry(srv, 1'b1, ERR_QUEUE_FULL);
          end else begin
            log_entry(p, 1'b1, ERR_NOTHING);
          end
        end
      endcase
    end
    if (expected_logs.size() > n0) expected_logs[expected_logs.size()-1].last_entry = 1'b1;
  endfunction

  // command driver: bursts with random gaps
  int unsigned burst_left, gap_left;
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      cmd_if.valid <= 1'b0;
      burst_left = 1;
      gap_left = 0;
    end else begin
      if (cmd_if.valid && cmd_if.ready) begin
        dispatch_cmd(cmd_if.data);
        accepted++;
      end
      if (!cmd_if.valid || cmd_if.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          cmd_if.valid <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          cmd_if.data  <= pending_cmds.pop_front();
          cmd_if.valid <= 1'b1;
          if (burst_left > 1) burst_left--;
          else begin
            burst_left = $urandom_range(1, 20);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          cmd_if.valid <= 1'b0;
        end
      end
    end
  end

  // log receiver: stall pattern re-drawn periodically from three modes, plus one long hold-off
  int unsigned hold_left, stall_mode;
  bit hold_done;
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      log_if.ready <= 1'b0;
      hold_left = 0;
      hold_done = 0;
      stall_mode = 0;
    end else begin
      if (cycles % 64 == 0) stall_mode = $urandom_range(0, 2);
      if (hold_left > 0) begin
        hold_left--;
        log_if.ready <= 1'b0;
      end else if (!hold_done && accepted >= 200) begin
        hold_done = 1;
        hold_left = HOLD_CYC;
        log_if.ready <= 1'b0;
      end else begin
        case (stall_mode)
          0: log_if.ready <= 1'b1;
          1: log_if.ready <= $urandom_range(0, 1);
          default: log_if.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // log checker
  always @(posedge clk_i) begin
    log_t want, got;
    if (rst_ni && log_if.valid && log_if.ready) begin
      got = log_if.data;
      log_seen++;
      if (got.is_error) err_seen++;
      if (expected_logs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected log entry %p", got);
      end else begin
        want = expected_logs.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"log mismatch: exp party=%0d err=%0b val=%0d last=%0b,",
                      " got party=%0d err=%0b val=%0d last=%0b"},
                     want.log_party, want.is_error, want.log_value, want.last_entry,
                     got.log_party, got.is_error, got.log_value, got.last_entry);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYC_LIMIT) begin
      $display("timeout after %0d cycles, %0d entries outstanding", cycles, expected_logs.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic queue_cmd(action_e a, int unsigned p, logic [7:0] ch);
    cmd_t c;
    c.action = a;
    c.party = p[2:0];
    c.item_char = ch;
    pending_cmds.push_back(c);
    issued++;
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      CFG_PARTY_COUNT:  sh_parties = val[3:0];
      CFG_CLIENT_STACK: sh_cstk = val;
      CFG_CLIENT_QUEUE: sh_cq = val;
      CFG_SERVER_STACK: sh_sstk = val;
      default:          sh_sq = val;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_config(int unsigned pc, int unsigned cs, int unsigned cq,
                            int unsigned ss, int unsigned sq);
    write_reg(CFG_PARTY_COUNT, pc[4:0]);
    write_reg(CFG_CLIENT_STACK, cs[4:0]);
    write_reg(CFG_CLIENT_QUEUE, cq[4:0]);
    write_reg(CFG_SERVER_STACK, ss[4:0]);
    write_reg(CFG_SERVER_QUEUE, sq[4:0]);
  endtask

  task automatic wait_idle();
    wait (accepted == issued && expected_logs.size() == 0);
    repeat (DRAIN_CYC) @(posedge clk_i);
  endtask

  task automatic random_cmds(int unsigned n);
    int unsigned np, r, p;
    action_e a;
    np = party_total();
    repeat (n) begin
      r = $urandom_range(0, 99);
      a = (r < 28) ? ACT_ADD_INT : (r < 55) ? ACT_ADD_PROC : (r < 82) ? ACT_SEND : ACT_OPERATE;
      p = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7) : $urandom_range(0, np - 1);
      queue_cmd(a, p, 8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_PARTY_COUNT;
    cfg_data_i = '0;
    cmd_if.valid = 1'b0;
    cmd_if.data = '0;
    log_if.ready = 1'b0;
    sh_parties = 4'd8;
    sh_cstk = 5'd16;
    sh_cq = 5'd16;
    sh_sstk = 5'd16;
    sh_sq = 5'd16;
    for (int i = 0; i < NPARTY; i++) begin
      stk_cnt[i] = 0;
      q_head[i] = 0;
      q_cnt[i] = 0;
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset defaults: empty sends, extremes, send by the server
    queue_cmd(ACT_SEND, 0, 8'h00);
    queue_cmd(ACT_OPERATE, 3, 8'h00);
    queue_cmd(ACT_ADD_INT, 0, 8'h00);
    queue_cmd(ACT_ADD_INT, 0, 8'hff);
    queue_cmd(ACT_ADD_PROC, 7, 8'hff);
    queue_cmd(ACT_ADD_PROC, 0, 8'h00);
    queue_cmd(ACT_SEND, 0, 8'h00);
    queue_cmd(ACT_SEND, 0, 8'h00);
    queue_cmd(ACT_SEND, 0, 8'h00);
    queue_cmd(ACT_SEND, 7, 8'h00);
    queue_cmd(ACT_OPERATE, 0, 8'h00);
    queue_cmd(ACT_OPERATE, 7, 8'h00);
    queue_cmd(ACT_OPERATE, 7, 8'h00);
    random_cmds(150);
    wait_idle();

    // tightest limits: full stack, full queue, server queue full on send, ignored party
    set_config(2, 1, 1, 1, 1);
    queue_cmd(ACT_ADD_INT, 0, 8'h49);
    queue_cmd(ACT_ADD_INT, 0, 8'h41);
    queue_cmd(ACT_ADD_PROC, 0, 8'h53);
    queue_cmd(ACT_ADD_PROC, 0, 8'h4f);
    queue_cmd(ACT_SEND, 0, 8'h00);
    queue_cmd(ACT_SEND, 0, 8'h00);
    queue_cmd(ACT_ADD_INT, 5, 8'h31);
    queue_cmd(ACT_SEND, 5, 8'h00);
    queue_cmd(ACT_SEND, 1, 8'h00);
    random_cmds(120);
    wait_idle();

    // out-of-range values clamp; unknown index is ignored
    set_config(0, 0, 0, 31, 31);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_IDX_UNUSED;
    cfg_data_i <= 5'd1;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    random_cmds(100);
    wait_idle();

    // limits lowered below current fill
    set_config(15, 4, 3, 2, 5);
    random_cmds(140);
    wait_idle();

    set_config(5, 16, 16, 16, 16);
    random_cmds(180);
    wait_idle();

    $display("%0d commands transferred, %0d log entries checked (%0d errors logged)",
             accepted, log_seen, err_seen);
    $display("five register settings incl. clamped extremes; %0d mismatches", mismatches);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### files.f
hdl/iapd_pkg.sv
hdl/iapd_if.sv
hdl/iapd_front.sv
hdl/iapd_back.sv
hdl/interrupt_and_process_dispatcher_top.sv
hdl/iapd_checker.sv
verif/tb.sv
